### rtl/core/pls_pkg.sv
// Shared constants and types for the positional list store.
`timescale 1ns / 1ps

package pls_pkg;

	// Fixed port widths
	localparam int OP_W     = 3;
	localparam int POS_W    = 5;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Operation codes
	localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
	localparam logic [OP_W-1:0] OP_DELETE   = 3'd1;
	localparam logic [OP_W-1:0] OP_RETRIEVE = 3'd2;
	localparam logic [OP_W-1:0] OP_REPLACE  = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	// Per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic del;
		logic rep;
	} cell_ctrl_t;

endpackage

### rtl/core/pls_cell.sv
// One list slot: holds an entry and shifts with its neighbors on insert and delete.
`timescale 1ns / 1ps

module pls_cell #(
	parameter int IDX   = 0,
	parameter int WIDTH = 32,
	parameter int CMPW  = 5
) (
	input  logic                clk,
	input  pls_pkg::cell_ctrl_t ctrl,
	input  logic [CMPW-1:0]     pos,
	input  logic [CMPW-1:0]     cnt,
	input  logic [WIDTH-1:0]    wr_value,
	input  logic [WIDTH-1:0]    left_value,
	input  logic [WIDTH-1:0]    right_value,
	output logic [WIDTH-1:0]    value
);
	import pls_pkg::*;

	localparam logic [CMPW-1:0] MY_IDX  = CMPW'(IDX);
	localparam logic [CMPW-1:0] NXT_IDX = CMPW'(IDX + 1);

	logic [WIDTH-1:0] value_q;
	logic             at_pos;
	logic             take_wr;
	logic             take_left;
	logic             take_right;

	// Decide this slot's move from its own index
	always_comb begin
		at_pos     = (MY_IDX == pos);
		take_wr    = (ctrl.ins || ctrl.rep) && at_pos;
		take_left  = ctrl.ins && (MY_IDX > pos) && (MY_IDX <= cnt);
		take_right = ctrl.del && (MY_IDX >= pos) && (NXT_IDX < cnt);
	end

	// Load, shift or hold
	always_ff @(posedge clk) begin
		priority if (take_wr) begin
			value_q <= wr_value;
		end else if (take_left) begin
			value_q <= left_value;
		end else if (take_right) begin
			value_q <= right_value;
		end else begin
			value_q <= value_q;
		end
	end

	assign value = value_q;

endmodule

### rtl/core/positional_list_store_unit.sv
// Top level of the positional list store: command decode, cell row and result register.
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY entries held in a row of cells, one entry per cell.
// Every request (insert, delete, retrieve, replace, clear) is handled by the whole row:
// all cells compare their index with the position and shift in parallel, and the
// result lands in a single output register the cycle after the request is taken.
// A new request is taken every cycle as long as that result register is empty or
// is being drained in the same cycle, so the sustained rate is one request per
// cycle; the output register's drain is the only thing that holds requests back.
// Insert into a full list returns status 1 and a bad position returns status 2;
// either way the list is left unchanged. The entry storage has no reset and needs
// no clearing pass; only the entry count and the result valid flag are reset.
module positional_list_store_unit #(
	parameter int CAPACITY    = 16,
	parameter int ENTRY_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [pls_pkg::OP_W-1:0]        operation,
	input  logic [pls_pkg::POS_W-1:0]       position,
	input  logic signed [pls_pkg::VALUE_W-1:0] item_value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [pls_pkg::VALUE_W-1:0] read_value,
	output logic [pls_pkg::STATUS_W-1:0]    status,
	output logic [pls_pkg::COUNT_W-1:0]     entry_count_out,
	output logic                            is_empty
);
	import pls_pkg::*;

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          cnt_next;
	logic [CMPW-1:0]        cnt_x;
	logic [CMPW-1:0]        pos_x;
	logic                   accept;
	logic                   is_full;
	logic                   in_range;
	logic                   ins_ok;
	logic                   rd_en;
	logic [STATUS_W-1:0]    st;
	cell_ctrl_t             ctrl;
	logic [ENTRY_WIDTH-1:0] wr_value;
	logic [ENTRY_WIDTH-1:0] cell_value [CAPACITY];
	logic [ENTRY_WIDTH-1:0] sel_value;
	logic [VALUE_W-1:0]     sel_value32;

	logic                   out_valid_q;
	logic [VALUE_W-1:0]     read_value_q;
	logic [STATUS_W-1:0]    status_q;
	logic [CMPW-1:0]        count_q;

	// Take a request when the result register is free or draining
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	assign cnt_x    = CMPW'(cnt_q);
	assign pos_x    = CMPW'(position);
	assign is_full  = (cnt_x == CMPW'(CAPACITY));
	assign in_range = (pos_x < cnt_x);
	assign ins_ok   = !is_full && (pos_x <= cnt_x);

	// Decode the request
	always_comb begin
		ctrl     = '0;
		st       = ST_OK;
		rd_en    = 1'b0;
		cnt_next = cnt_q;
		unique case (operation)
			OP_INSERT: begin
				if (is_full) begin
					st = ST_FULL;
				end else if (!ins_ok) begin
					st = ST_RANGE;
				end else begin
					ctrl.ins = accept;
					cnt_next = cnt_q + CW'(1);
				end
			end
			OP_DELETE: begin
				if (!in_range) begin
					st = ST_RANGE;
				end else begin
					ctrl.del = accept;
					rd_en    = 1'b1;
					cnt_next = cnt_q - CW'(1);
				end
			end
			OP_RETRIEVE: begin
				if (!in_range) begin
					st = ST_RANGE;
				end else begin
					rd_en = 1'b1;
				end
			end
			OP_REPLACE: begin
				if (!in_range) begin
					st = ST_RANGE;
				end else begin
					ctrl.rep = accept;
				end
			end
			OP_CLEAR: begin
				cnt_next = '0;
			end
			default: begin
			end
		endcase
	end

	// Fit the request value to the entry width and the entry to the port width
	generate
		if (ENTRY_WIDTH <= VALUE_W) begin : g_wr_narrow
			assign wr_value = item_value[ENTRY_WIDTH-1:0];
		end else begin : g_wr_wide
			assign wr_value = {{(ENTRY_WIDTH-VALUE_W){1'b0}}, item_value};
		end
		if (ENTRY_WIDTH >= VALUE_W) begin : g_rd_wide
			assign sel_value32 = sel_value[VALUE_W-1:0];
		end else begin : g_rd_narrow
			assign sel_value32 = {{(VALUE_W-ENTRY_WIDTH){1'b0}}, sel_value};
		end
	endgenerate

	// Row of cells, each wired to its neighbors
	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			logic [ENTRY_WIDTH-1:0] left_v;
			logic [ENTRY_WIDTH-1:0] right_v;
			if (i == 0) begin : g_first
				assign left_v = '0;
			end else begin : g_mid_l
				assign left_v = cell_value[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign right_v = '0;
			end else begin : g_mid_r
				assign right_v = cell_value[i+1];
			end
			pls_cell #(
				.IDX   (i),
				.WIDTH (ENTRY_WIDTH),
				.CMPW  (CMPW)
			) u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.pos         (pos_x),
				.cnt         (cnt_x),
				.wr_value    (wr_value),
				.left_value  (left_v),
				.right_value (right_v),
				.value       (cell_value[i])
			);
		end
	endgenerate

	// Pick the cell at the requested position
	always_comb begin
		sel_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (CMPW'(i) == pos_x) begin
				sel_value = sel_value | cell_value[i];
			end
		end
	end

	// Hold the entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= cnt_next;
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= rd_en ? sel_value32 : '0;
			status_q     <= st;
			count_q      <= CMPW'(cnt_next);
		end
	end

	assign out_valid       = out_valid_q;
	assign read_value      = read_value_q;
	assign status          = status_q;
	assign entry_count_out = count_q[COUNT_W-1:0];
	assign is_empty        = (count_q == '0);

endmodule

### rtl/core/pls_checker.sv
// Port-level checks for the positional list store, bound to the top level.
`timescale 1ns / 1ps

module pls_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic [pls_pkg::OP_W-1:0]           operation,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [pls_pkg::VALUE_W-1:0]        read_value,
	input logic [pls_pkg::STATUS_W-1:0]       status,
	input logic [pls_pkg::COUNT_W-1:0]        entry_count_out,
	input logic                               is_empty
);
	import pls_pkg::*;

	// A waiting, stalled result must hold back new requests
	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("request taken while result is stalled");

	// An accepted clear shows up next cycle as an empty list
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && operation == OP_CLEAR |=> out_valid && is_empty)
		else $error("clear did not report an empty list");

	// An empty list reports zero entries
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> entry_count_out == '0)
		else $error("empty flag with nonzero count");

	// Failed requests return no data
	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> read_value == '0)
		else $error("data returned with error status");

	// Only defined status codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_OK || status == ST_FULL || status == ST_RANGE)
		else $error("undefined status code");

endmodule

bind positional_list_store_unit pls_checker u_pls_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.operation       (operation),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.read_value      (read_value),
	.status          (status),
	.entry_count_out (entry_count_out),
	.is_empty        (is_empty)
);

### bench/tb_top.sv
// Self-checking testbench for the positional list store: directed corners, then random traffic.
`timescale 1ns / 1ps

module tb_top;
	import pls_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int HALF_PERIOD = 2;
	localparam int RESET_CYCLES = 11;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS = 440;
	localparam int PAUSE_ITEMS = 30;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	// Codes the block leaves without effect
	localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic [VALUE_W-1:0]  value;
		logic [STATUS_W-1:0] stat;
		logic [COUNT_W-1:0]  count;
		logic                empty;
	} list_reply_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [OP_W-1:0]            operation = '0;
	logic [POS_W-1:0]           position = '0;
	logic signed [VALUE_W-1:0]  item_value = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [VALUE_W-1:0]  read_value;
	logic [STATUS_W-1:0]        status;
	logic [COUNT_W-1:0]         entry_count_out;
	logic                       is_empty;

	// Shadow copy of the list
	logic [VALUE_W-1:0] list_mem [LIST_DEPTH];
	int unsigned        list_len = 0;
	list_reply_t        list_replies_due [$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned error_count = 0;
	int unsigned quiet_cycles = 0;

	positional_list_store_unit #(
		.CAPACITY   (LIST_DEPTH),
		.ENTRY_WIDTH(VALUE_W)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.position       (position),
		.item_value     (item_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.read_value     (read_value),
		.status         (status),
		.entry_count_out(entry_count_out),
		.is_empty       (is_empty)
	);

	initial begin
		forever #HALF_PERIOD clk = ~clk;
	end

	// Apply one request to the shadow list and return the reply it must produce
	function automatic list_reply_t predict_list_op(input logic [OP_W-1:0] op,
			input logic [POS_W-1:0] pos, input logic [VALUE_W-1:0] val);
		list_reply_t r;
		int i;
		r.value = '0;
		r.stat = ST_OK;
		case (op)
		OP_INSERT: begin
			if (list_len >= LIST_DEPTH) begin
				r.stat = ST_FULL;
			end else if (pos > list_len) begin
				r.stat = ST_RANGE;
			end else begin
				for (i = int'(list_len); i > pos; i--)
					list_mem[i] = list_mem[i - 1];
				list_mem[pos] = val;
				list_len++;
			end
		end
		OP_DELETE: begin
			if (pos >= list_len) begin
				r.stat = ST_RANGE;
			end else begin
				r.value = list_mem[pos];
				for (i = int'(pos); i + 1 < list_len; i++)
					list_mem[i] = list_mem[i + 1];
				list_len--;
			end
		end
		OP_RETRIEVE: begin
			if (pos >= list_len)
				r.stat = ST_RANGE;
			else
				r.value = list_mem[pos];
		end
		OP_REPLACE: begin
			if (pos >= list_len)
				r.stat = ST_RANGE;
			else
				list_mem[pos] = val;
		end
		OP_CLEAR: begin
			list_len = 0;
		end
		default: begin
		end
		endcase
		r.count = COUNT_W'(list_len);
		r.empty = (list_len == 0);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
			input logic [VALUE_W-1:0] want);
		$display("%0t ns: %s: got %h, want %h", $time, what, got, want);
		error_count++;
	endtask

	// Send one request; starts and ends on a falling edge, valid left high
	task automatic send_list_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic [VALUE_W-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			operation <= OP_W'($urandom());
			position <= POS_W'($urandom());
			item_value <= $urandom();
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		position <= pos;
		item_value <= val;
		do @(posedge clk); while (in_stall);
		list_replies_due.push_back(predict_list_op(op, pos, val));
		@(negedge clk);
	endtask

	// Hold the sender off until every reply is back
	task automatic drain_replies();
		in_valid <= 1'b0;
		while (list_replies_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_directed_corners();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		// empty list: every positional access is out of range
		send_list_request(OP_RETRIEVE, '0, '0);
		send_list_request(OP_DELETE, '0, '0);
		send_list_request(OP_INSERT, 5'd1, 32'h1234_5678);
		// fill with the value extremes first, then random spots up to capacity
		send_list_request(OP_INSERT, '0, 32'h8000_0000);
		send_list_request(OP_INSERT, 5'd1, 32'h7FFF_FFFF);
		send_list_request(OP_INSERT, '0, '1);
		while (list_len < LIST_DEPTH)
			send_list_request(OP_INSERT, POS_W'($urandom_range(list_len)), $urandom());
		// full list: full wins over a bad position
		send_list_request(OP_INSERT, POS_MAX, '0);
		send_list_request(OP_DELETE, POS_W'(LIST_DEPTH), '0);
		send_list_request(OP_REPLACE, POS_W'(LIST_DEPTH - 1), '0);
		send_list_request(OP_RETRIEVE, POS_W'(LIST_DEPTH - 1), '0);
		send_list_request(OP_DELETE, '0, '0);
		// unused codes change nothing
		send_list_request(OP_SPARE_FIRST, '0, '1);
		send_list_request(OP_SPARE_LAST, POS_MAX, '1);
		send_list_request(OP_CLEAR, '0, '0);
		send_list_request(OP_RETRIEVE, '0, '0);
	endtask

	// Random traffic that swings the list between empty and full
	task automatic test_random_traffic(input int unsigned n_items, input int unsigned idle_pct,
			input int unsigned stall_pct);
		logic [OP_W-1:0]    op;
		logic [POS_W-1:0]   pos;
		logic [VALUE_W-1:0] val;
		int unsigned        roll;
		bit                 growing;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		growing = 1'b1;
		repeat (n_items) begin
			if (list_len == LIST_DEPTH)
				growing = 1'b0;
			else if (list_len == 0)
				growing = 1'b1;
			roll = $urandom_range(99);
			if (roll < 1)
				op = OP_CLEAR;
			else if (roll < 4)
				op = OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
			else if (roll < 40)
				op = growing ? OP_INSERT : OP_DELETE;
			else if (roll < 55)
				op = growing ? OP_DELETE : OP_INSERT;
			else if (roll < 80)
				op = OP_RETRIEVE;
			else
				op = OP_REPLACE;
			// mostly legal positions, some anywhere in the field
			if ($urandom_range(99) < 12)
				pos = POS_W'($urandom_range(POS_MAX));
			else if (op == OP_INSERT)
				pos = POS_W'($urandom_range(list_len));
			else if (list_len == 0)
				pos = '0;
			else
				pos = POS_W'($urandom_range(list_len - 1));
			val = $urandom();
			send_list_request(op, pos, val);
		end
	endtask

	task automatic test_pause_for_drain();
		test_random_traffic(PAUSE_ITEMS, 0, 55);
		drain_replies();
		test_random_traffic(PAUSE_ITEMS, 0, 55);
	endtask

	// Receiver stall pattern
	always @(negedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < recv_stall_pct);
	end

	// Check each accepted reply against the oldest prediction
	always @(posedge clk) begin
		list_reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (list_replies_due.size() == 0) begin
				report_mismatch("reply with none due", read_value, '0);
			end else begin
				want = list_replies_due.pop_front();
				if (read_value !== want.value)
					report_mismatch("read_value", read_value, want.value);
				if (status !== want.stat)
					report_mismatch("status", VALUE_W'(status), VALUE_W'(want.stat));
				if (entry_count_out !== want.count)
					report_mismatch("entry_count_out", VALUE_W'(entry_count_out),
						VALUE_W'(want.count));
				if (is_empty !== want.empty)
					report_mismatch("is_empty", VALUE_W'(is_empty), VALUE_W'(want.empty));
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_corners();
		test_random_traffic(PHASE_ITEMS, 0, 0);
		test_random_traffic(PHASE_ITEMS, 55, 0);
		test_random_traffic(PHASE_ITEMS, 0, 55);
		test_random_traffic(PHASE_ITEMS, 25, 25);
		test_pause_for_drain();
		drain_replies();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
